// ----- hw/rtl/lzfw_pkg.sv -----
// Package for the forward window writer: payload structs, command word,
// operation and register codes, sizing constants. No dependencies.
`timescale 1ns / 1ps

package lzfw_pkg;

  // Sizing
  localparam int BUF_DEPTH   = 65536;
  localparam int MAX_COUNT   = 64;
  localparam int ADDR_W      = $clog2(BUF_DEPTH);
  localparam int POS_W       = 17;
  localparam int DIST_W      = 16;
  localparam int CNT_W       = 7;
  localparam int QUEUE_DEPTH = 4;

  // Operation codes
  localparam logic [1:0] OP_LITERAL   = 2'd0;
  localparam logic [1:0] OP_COPY      = 2'd1;
  localparam logic [1:0] OP_FILL_COPY = 2'd2;

  // Configuration register indexes
  localparam logic REG_START = 1'b0;
  localparam logic REG_END   = 1'b1;

  typedef struct packed {
    logic [1:0]        operation;
    logic [7:0]        literal_byte;
    logic [DIST_W-1:0] distance;
    logic [CNT_W-1:0]  count;
    logic [7:0]        fill_byte;
  } in_item_t;

  typedef struct packed {
    logic        has_byte;
    logic [7:0]  byte_value;
    logic [15:0] byte_address;
    logic        status;
    logic        last;
  } out_item_t;

  typedef enum logic {
    CMD_RESULT,
    CMD_WRITE
  } cmd_kind_t;

  // Work handed from front to back. A literal is a one-byte write whose
  // byte travels in the fill field.
  typedef struct packed {
    cmd_kind_t         kind;
    logic              status;
    logic [7:0]        fill;
    logic [ADDR_W-1:0] addr;
    logic [DIST_W-1:0] back_dist;
    logic [CNT_W-1:0]  cnt;
    logic [CNT_W-1:0]  pre;
  } cmd_t;

endpackage

// ----- hw/rtl/lz_forward_window_writer.sv -----
// A written byte passes through the command queue, the back end's read and
// write states and the result register; an error or empty-copy result, through
// the queue and the result register. The back end takes each command when idle,
// then reads and writes the RAM for each byte, waiting on a stalled result. A
// 4-entry queue decouples input from output. Reset (rst_n, synchronous) empties
// the queue and result register and sets start 0, end 65536, write position 0.
`timescale 1ns / 1ps

module lz_forward_window_writer (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [lzfw_pkg::POS_W-1:0]        cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  lzfw_pkg::in_item_t                in_item,
  output logic                              out_valid,
  input  logic                              out_stall,
  output lzfw_pkg::out_item_t               out_item
);

  lzfw_pkg::cmd_t front_cmd;
  lzfw_pkg::cmd_t head_cmd;
  logic           push;
  logic           q_full;
  logic           head_valid;
  logic           pop;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  lzfw_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .push      (push),
    .item      (in_item),
    .cmd       (front_cmd)
  );

  lzfw_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (front_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  lzfw_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_item   (out_item),
    .out_stall  (out_stall)
  );

endmodule

// ----- hw/rtl/lzfw_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module lzfw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write when enabled; read every cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/lzfw_front.sv -----
// Front end: holds configuration and the write position, checks each
// accepted item and turns it into a command. Uses lzfw_pkg.
`timescale 1ns / 1ps

module lzfw_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [lzfw_pkg::POS_W-1:0]        cfg_wdata,
  input  logic                              push,
  input  lzfw_pkg::in_item_t                item,
  output lzfw_pkg::cmd_t                    cmd
);

  logic [lzfw_pkg::POS_W-1:0] start_r, start_nxt;
  logic [lzfw_pkg::POS_W-1:0] end_r, end_nxt;
  logic [lzfw_pkg::POS_W-1:0] wp_r, wp_nxt;
  logic [lzfw_pkg::POS_W-1:0] end_use;
  logic [lzfw_pkg::POS_W:0]   pos_cnt;
  logic [lzfw_pkg::POS_W:0]   src_sum;
  logic [lzfw_pkg::POS_W:0]   pre_diff;
  logic                       src_early;
  logic                       copy_err;
  logic                       lit_err;

  // Clamp end to the buffer and form the range sums
  always_comb begin
    end_use   = (end_r < lzfw_pkg::POS_W'(lzfw_pkg::BUF_DEPTH)) ? end_r
                : lzfw_pkg::POS_W'(lzfw_pkg::BUF_DEPTH);
    pos_cnt   = {1'b0, wp_r} + (lzfw_pkg::POS_W+1)'(item.count);
    src_sum   = {1'b0, start_r} + (lzfw_pkg::POS_W+1)'(item.distance);
    src_early = src_sum > {1'b0, wp_r};
    pre_diff  = src_sum - {1'b0, wp_r};
    lit_err   = wp_r >= end_use;
    copy_err  = (item.operation != lzfw_pkg::OP_COPY &&
                 item.operation != lzfw_pkg::OP_FILL_COPY) ||
                item.distance == '0 ||
                item.count > lzfw_pkg::CNT_W'(lzfw_pkg::MAX_COUNT) ||
                pos_cnt > {1'b0, end_use} ||
                (item.operation == lzfw_pkg::OP_COPY && src_early);
  end

  // Classify the item and advance the write position
  always_comb begin
    cmd.kind      = lzfw_pkg::CMD_RESULT;
    cmd.status    = 1'b1;
    cmd.fill      = item.fill_byte;
    cmd.addr      = wp_r[lzfw_pkg::ADDR_W-1:0];
    cmd.back_dist = item.distance;
    cmd.cnt       = item.count;
    cmd.pre       = '0;
    wp_nxt        = wp_r;
    if (item.operation == lzfw_pkg::OP_LITERAL) begin
      if (!lit_err) begin
        cmd.kind   = lzfw_pkg::CMD_WRITE;
        cmd.status = 1'b0;
        cmd.fill   = item.literal_byte;
        cmd.cnt    = lzfw_pkg::CNT_W'(1);
        cmd.pre    = lzfw_pkg::CNT_W'(1);
        wp_nxt     = wp_r + lzfw_pkg::POS_W'(1);
      end
    end else if (!copy_err) begin
      cmd.status = 1'b0;
      if (item.count != '0) begin
        cmd.kind = lzfw_pkg::CMD_WRITE;
        wp_nxt   = pos_cnt[lzfw_pkg::POS_W-1:0];
        if (item.operation == lzfw_pkg::OP_FILL_COPY && src_early) begin
          cmd.pre = (pre_diff > (lzfw_pkg::POS_W+1)'(item.count)) ? item.count
                    : pre_diff[lzfw_pkg::CNT_W-1:0];
        end
      end
    end
  end

  // Hold configuration; a start write reloads the write position
  always_comb begin
    start_nxt = start_r;
    end_nxt   = end_r;
    if (cfg_we) begin
      if (cfg_index == lzfw_pkg::REG_START) begin
        start_nxt = cfg_wdata;
      end else begin
        end_nxt = cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
      end_r   <= lzfw_pkg::POS_W'(lzfw_pkg::BUF_DEPTH);
      wp_r    <= '0;
    end else begin
      start_r <= start_nxt;
      end_r   <= end_nxt;
      if (cfg_we && cfg_index == lzfw_pkg::REG_START) begin
        wp_r <= cfg_wdata;
      end else if (push) begin
        wp_r <= wp_nxt;
      end
    end
  end

endmodule

// ----- hw/rtl/lzfw_queue.sv -----
// Short command queue between front and back end. Uses lzfw_pkg.
`timescale 1ns / 1ps

module lzfw_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  lzfw_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output lzfw_pkg::cmd_t head_cmd
);

  localparam int PtrW = $clog2(lzfw_pkg::QUEUE_DEPTH);

  lzfw_pkg::cmd_t   entry_r [lzfw_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0]  wr_ptr_r;
  logic [PtrW-1:0]  rd_ptr_r;
  logic [PtrW:0]    fill_r, fill_nxt;

  assign full       = fill_r == (PtrW+1)'(lzfw_pkg::QUEUE_DEPTH);
  assign head_valid = fill_r != '0;
  assign head_cmd   = entry_r[rd_ptr_r];

  always_comb begin
    fill_nxt = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + (PtrW+1)'(1);
    end else if (pop && !push) begin
      fill_nxt = fill_r - (PtrW+1)'(1);
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PtrW'(1);
      end
      fill_r <= fill_nxt;
    end
  end

endmodule

// ----- hw/rtl/lzfw_back.sv -----
// Back end: runs commands byte by byte against the history RAM and drives
// the result register. Uses lzfw_pkg and lzfw_ram.
`timescale 1ns / 1ps

module lzfw_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                head_valid,
  input  lzfw_pkg::cmd_t      head_cmd,
  output logic                pop,
  output logic                out_valid,
  output lzfw_pkg::out_item_t out_item,
  input  logic                out_stall
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_WRITE
  } state_t;

  state_t                        state_r;
  logic                          out_valid_r;
  lzfw_pkg::out_item_t           out_item_r;
  logic [lzfw_pkg::ADDR_W-1:0]   cur_r;
  logic [lzfw_pkg::ADDR_W-1:0]   src_r;
  logic [lzfw_pkg::CNT_W-1:0]    left_r;
  logic [lzfw_pkg::CNT_W-1:0]    pre_r;
  logic [7:0]                    fill_r;
  logic [7:0]                    rdata;
  logic [7:0]                    wr_byte;
  logic                          out_free;
  logic                          ram_we;
  logic                          out_load;

  assign out_free  = !out_valid_r || !out_stall;
  assign pop       = state_r == S_IDLE && head_valid &&
                     (head_cmd.kind == lzfw_pkg::CMD_WRITE || out_free);
  assign ram_we    = state_r == S_WRITE && out_free;
  assign out_load  = ram_we ||
                     (state_r == S_IDLE && pop && head_cmd.kind == lzfw_pkg::CMD_RESULT);
  assign wr_byte   = (pre_r != '0) ? fill_r : rdata;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  lzfw_ram #(
    .WIDTH (8),
    .DEPTH (lzfw_pkg::BUF_DEPTH)
  ) u_history (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cur_r),
    .wdata (wr_byte),
    .raddr (src_r),
    .rdata (rdata)
  );

  // Sequence commands and hold the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (pop) begin
            if (head_cmd.kind == lzfw_pkg::CMD_RESULT) begin
              out_item_r.has_byte     <= 1'b0;
              out_item_r.byte_value   <= '0;
              out_item_r.byte_address <= '0;
              out_item_r.status       <= head_cmd.status;
              out_item_r.last         <= 1'b1;
            end else begin
              cur_r   <= head_cmd.addr;
              src_r   <= head_cmd.addr - lzfw_pkg::ADDR_W'(head_cmd.back_dist);
              left_r  <= head_cmd.cnt;
              pre_r   <= head_cmd.pre;
              fill_r  <= head_cmd.fill;
              state_r <= S_READ;
            end
          end
        end
        S_READ: begin
          state_r <= S_WRITE;
        end
        S_WRITE: begin
          if (out_free) begin
            out_item_r.has_byte     <= 1'b1;
            out_item_r.byte_value   <= wr_byte;
            out_item_r.byte_address <= 16'(cur_r);
            out_item_r.status       <= 1'b0;
            out_item_r.last         <= left_r == lzfw_pkg::CNT_W'(1);
            cur_r  <= cur_r + lzfw_pkg::ADDR_W'(1);
            src_r  <= src_r + lzfw_pkg::ADDR_W'(1);
            left_r <= left_r - lzfw_pkg::CNT_W'(1);
            if (pre_r != '0) begin
              pre_r <= pre_r - lzfw_pkg::CNT_W'(1);
            end
            state_r <= (left_r == lzfw_pkg::CNT_W'(1)) ? S_IDLE : S_READ;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- hw/rtl/lzfw_checker.sv -----
// Port-level checks for the forward window writer, bound to the top level.
// Uses lzfw_pkg.
`timescale 1ns / 1ps

module lzfw_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input lzfw_pkg::out_item_t out_item
);

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result beat changed while stalled");

  // Error results close their item and carry no byte
  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status |-> out_item.last && !out_item.has_byte)
    else $error("error result malformed");

  // A beat without a byte is the only result of its item, with zero payload
  a_nobyte_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.has_byte |->
      out_item.last && out_item.byte_value == 8'd0 &&
      out_item.byte_address == 16'd0)
    else $error("byteless result malformed");

  // Drop results on reset
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind lz_forward_window_writer lzfw_checker u_lzfw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
